### design/dbm_pkg.sv
// Shared types and constants for the two-wire debug byte master.
package dbm_pkg;

	localparam logic [15:0] HALF_PERIOD_RESET = 16'd4;

	typedef enum logic [1:0] {
		OP_NONE  = 2'd0,
		OP_WRITE = 2'd1,
		OP_READ  = 2'd2,
		OP_IDLE  = 2'd3
	} op_t;

	typedef enum logic [9:0] {
		PH_IDLE    = 10'b00_0000_0001,
		PH_START_A = 10'b00_0000_0010,
		PH_START_B = 10'b00_0000_0100,
		PH_START_C = 10'b00_0000_1000,
		PH_BIT_LO  = 10'b00_0001_0000,
		PH_BIT_HI  = 10'b00_0010_0000,
		PH_STOP_LO = 10'b00_0100_0000,
		PH_STOP_HI = 10'b00_1000_0000,
		PH_IDL_LO  = 10'b01_0000_0000,
		PH_IDL_HI  = 10'b10_0000_0000
	} phase_t;

	typedef struct packed {
		logic [1:0] func;
		logic       with_start;
		logic [7:0] byte_out;
		logic       stop_level;
		logic [7:0] idle_count;
		logic       data_in;
	} req_t;

	typedef struct packed {
		logic       clock_line;
		logic       data_line;
		logic       data_drive;
		logic       busy_res;
		logic       read_valid;
		logic [7:0] read_byte;
		logic       rejected;
	} res_t;

	typedef struct packed {
		phase_t      phase;
		logic [15:0] div_cnt;
		logic [2:0]  bit_idx;
		logic [7:0]  shift;
		op_t         op;
		logic        stop_bit;
		logic [7:0]  idle_rem;
		logic        clk_lvl;
		logic        data_lvl;
		logic        drive;
	} state_t;

endpackage

### design/dbm_req_if.sv
// Request and result channel interfaces with valid/ready handshake.
interface dbm_req_if;
	logic          valid;
	logic          ready;
	dbm_pkg::req_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

interface dbm_res_if;
	logic          valid;
	logic          ready;
	dbm_pkg::res_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

### design/dbm_engine.sv
// Line state machine: serial clock divider, phase sequencing and byte shifting.
module dbm_engine (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          adv,
	input  logic [15:0]   half,
	input  dbm_pkg::req_t item,
	output dbm_pkg::res_t result
);

	localparam dbm_pkg::state_t STATE_RESET = '{
		phase:    dbm_pkg::PH_IDLE,
		div_cnt:  16'd0,
		bit_idx:  3'd0,
		shift:    8'd0,
		op:       dbm_pkg::OP_NONE,
		stop_bit: 1'b0,
		idle_rem: 8'd0,
		clk_lvl:  1'b1,
		data_lvl: 1'b1,
		drive:    1'b1
	};

	dbm_pkg::state_t cur_q;
	dbm_pkg::state_t nxt;
	dbm_pkg::phase_t tgt;
	dbm_pkg::op_t    func_op;
	logic            do_enter;
	logic            do_finish;
	logic            rd_done;
	logic            rej;

	assign func_op = dbm_pkg::op_t'(item.func);

	always_comb begin
		nxt       = cur_q;
		tgt       = dbm_pkg::PH_IDLE;
		do_enter  = 1'b0;
		do_finish = 1'b0;
		rd_done   = 1'b0;
		rej       = 1'b0;
		if (cur_q.op != dbm_pkg::OP_NONE) begin
			rej = (func_op != dbm_pkg::OP_NONE);
			if (({1'b0, cur_q.div_cnt} + 17'd1) < {1'b0, half}) begin
				nxt.div_cnt = cur_q.div_cnt + 16'd1;
			end else begin
				unique case (cur_q.phase)
					dbm_pkg::PH_START_A: begin
						do_enter = 1'b1;
						tgt      = dbm_pkg::PH_START_B;
					end
					dbm_pkg::PH_START_B: begin
						do_enter = 1'b1;
						tgt      = dbm_pkg::PH_START_C;
					end
					dbm_pkg::PH_START_C: begin
						do_enter = 1'b1;
						tgt      = dbm_pkg::PH_BIT_LO;
					end
					dbm_pkg::PH_BIT_LO: begin
						if (cur_q.op == dbm_pkg::OP_READ) begin
							nxt.shift = {item.data_in, cur_q.shift[7:1]};
						end
						do_enter = 1'b1;
						tgt      = dbm_pkg::PH_BIT_HI;
					end
					dbm_pkg::PH_BIT_HI: begin
						if (cur_q.op == dbm_pkg::OP_WRITE) begin
							nxt.shift = {1'b0, cur_q.shift[7:1]};
						end
						do_enter = 1'b1;
						if (cur_q.bit_idx == 3'd7) begin
							nxt.bit_idx = 3'd0;
							tgt         = dbm_pkg::PH_STOP_LO;
						end else begin
							nxt.bit_idx = cur_q.bit_idx + 3'd1;
							tgt         = dbm_pkg::PH_BIT_LO;
						end
					end
					dbm_pkg::PH_STOP_LO: begin
						do_enter = 1'b1;
						tgt      = dbm_pkg::PH_STOP_HI;
					end
					dbm_pkg::PH_STOP_HI: begin
						rd_done   = (cur_q.op == dbm_pkg::OP_READ);
						do_finish = 1'b1;
					end
					dbm_pkg::PH_IDL_LO: begin
						do_enter = 1'b1;
						tgt      = dbm_pkg::PH_IDL_HI;
					end
					dbm_pkg::PH_IDL_HI: begin
						nxt.idle_rem = cur_q.idle_rem - 8'd1;
						if (nxt.idle_rem == 8'd0) begin
							do_finish = 1'b1;
						end else begin
							do_enter = 1'b1;
							tgt      = dbm_pkg::PH_IDL_LO;
						end
					end
					default: begin
						do_finish = 1'b1;
					end
				endcase
			end
		end else if (func_op != dbm_pkg::OP_NONE) begin
			nxt.op       = func_op;
			nxt.shift    = (func_op == dbm_pkg::OP_WRITE) ? item.byte_out : 8'd0;
			nxt.stop_bit = item.stop_level;
			nxt.bit_idx  = 3'd0;
			nxt.drive    = 1'b1;
			if (func_op == dbm_pkg::OP_IDLE) begin
				nxt.data_lvl = 1'b1;
				nxt.idle_rem = item.idle_count;
				if (item.idle_count == 8'd0) begin
					do_finish = 1'b1;
				end else begin
					do_enter = 1'b1;
					tgt      = dbm_pkg::PH_IDL_LO;
				end
			end else begin
				do_enter = 1'b1;
				tgt      = item.with_start ? dbm_pkg::PH_START_A : dbm_pkg::PH_BIT_LO;
			end
		end

		if (do_finish) begin
			nxt.phase   = dbm_pkg::PH_IDLE;
			nxt.op      = dbm_pkg::OP_NONE;
			nxt.div_cnt = 16'd0;
			nxt.bit_idx = 3'd0;
		end

		if (do_enter) begin
			nxt.phase   = tgt;
			nxt.div_cnt = 16'd0;
			unique case (tgt)
				dbm_pkg::PH_START_A: begin
					nxt.clk_lvl = 1'b0;
				end
				dbm_pkg::PH_START_B: begin
					nxt.clk_lvl  = 1'b0;
					nxt.data_lvl = 1'b0;
				end
				dbm_pkg::PH_BIT_LO: begin
					nxt.clk_lvl = 1'b0;
					if (nxt.op == dbm_pkg::OP_READ) begin
						nxt.drive = 1'b0;
					end else begin
						nxt.data_lvl = nxt.shift[0];
					end
				end
				dbm_pkg::PH_STOP_LO: begin
					nxt.clk_lvl  = 1'b0;
					nxt.drive    = 1'b1;
					nxt.data_lvl = nxt.stop_bit;
				end
				dbm_pkg::PH_IDL_LO: begin
					nxt.clk_lvl = 1'b0;
				end
				dbm_pkg::PH_START_C, dbm_pkg::PH_BIT_HI, dbm_pkg::PH_STOP_HI,
				dbm_pkg::PH_IDL_HI: begin
					nxt.clk_lvl = 1'b1;
				end
				default: begin
					nxt.clk_lvl = cur_q.clk_lvl;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q <= STATE_RESET;
		end else if (adv) begin
			cur_q <= nxt;
		end
	end

	always_comb begin
		result.clock_line = nxt.clk_lvl;
		result.data_line  = nxt.data_lvl;
		result.data_drive = nxt.drive;
		result.busy_res   = (nxt.op != dbm_pkg::OP_NONE);
		result.read_valid = rd_done;
		result.read_byte  = rd_done ? nxt.shift : 8'd0;
		result.rejected   = rej;
	end

endmodule

### design/two_wire_debug_byte_master.sv
// Top level of the two-wire debug byte master with request and result registers.
//
//   Channel  Dir  Handshake      Contents
//   req      in   valid/ready    func, with_start, byte_out, stop_level, idle_count, data_in
//   res      out  valid/ready    clock_line, data_line, data_drive, busy_res, read_valid,
//                                read_byte, rejected
//   cfg      in   write enable   half_period_cycles (16 bits)
//
// Every request yields exactly one result, registered first in the request register and then in the result register.
// A request is taken in every cycle unless the input stalls; the line state machine updates once per request.
// Reset puts both lines high with the data line driven and the half period at HALF_PERIOD_RESET.
// When the result register is full and not taken, the request register holds and
// the input stalls; ready returns as soon as the result moves on.
module two_wire_debug_byte_master (
	input  logic        clk,
	input  logic        arst_n,
	dbm_req_if.sink     req,
	dbm_res_if.source   res,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata
);

	logic          valid_s1;
	dbm_pkg::req_t item_s1;
	logic          valid_s2;
	dbm_pkg::res_t result_s2;
	dbm_pkg::res_t result;
	logic [15:0]   half_q;
	logic          adv;

	assign adv       = valid_s1 && (!valid_s2 || res.ready);
	assign req.ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_q <= dbm_pkg::HALF_PERIOD_RESET;
		end else if (cfg_we) begin
			half_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (req.ready) begin
				valid_s1 <= req.valid;
			end
			if (adv) begin
				valid_s2 <= 1'b1;
			end else if (res.ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			item_s1 <= req.payload;
		end
		if (adv) begin
			result_s2 <= result;
		end
	end

	dbm_engine u_engine (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.half   (half_q),
		.item   (item_s1),
		.result (result)
	);

	assign res.valid   = valid_s2;
	assign res.payload = result_s2;

endmodule

### design/dbm_checker.sv
// Port-level assertions for the two-wire debug byte master, bound to the top level.
module dbm_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          res_valid,
	input logic          res_ready,
	input dbm_pkg::res_t res_payload
);

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_payload))
		else $error("Result changed while stalled.");

	a_read_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_payload.read_valid |-> !res_payload.busy_res)
		else $error("Read completion reported while still busy.");

	a_read_byte_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_payload.read_valid |-> res_payload.read_byte == 8'd0)
		else $error("Read byte nonzero without a completed read.");

	a_release_busy: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_payload.data_drive |-> res_payload.busy_res)
		else $error("Data line released outside a command.");

endmodule

bind two_wire_debug_byte_master dbm_checker u_dbm_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.res_valid   (res.valid),
	.res_ready   (res.ready),
	.res_payload (res.payload)
);
